@@ hdl/day_count_to_calendar_date_macros.svh @@
// Assertion macros shared by the day count to calendar date design.
`ifndef DAY_COUNT_TO_CALENDAR_DATE_MACROS_SVH
`define DAY_COUNT_TO_CALENDAR_DATE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DCCD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DCCD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dccd_pkg.sv @@
// Constants and the month start table for the day count to calendar date block.
`timescale 1ns / 1ps

package dccd_pkg;

  localparam int BASE_YEAR      = 1900;
  localparam int DAY_BITS       = 17;
  localparam int ANCHOR_YEAR    = 1970;
  localparam int ANCHOR_WEEKDAY = 4;

  localparam int YEAR_BITS  = 12;
  localparam int MONTH_BITS = 4;
  localparam int MDAY_BITS  = 5;
  localparam int WDAY_BITS  = 3;

  localparam int DAYS_PER_WEEK = 7;
  localparam int ERA_YEARS     = 400;
  localparam int ERA_DAYS      = 146097;
  localparam int CENT_DAYS     = 36524;
  localparam int QUAD_DAYS     = 1460;
  localparam int YEAR_DAYS     = 365;
  localparam int CENTS_PER_ERA = 4;
  localparam int YEARS_PER_CENT = 100;
  // Day of a March-based year on which January 1 falls.
  localparam int MAR_TO_JAN    = 306;
  // Month index (March is 0) of January in the March-based year.
  localparam int MP_JAN        = 10;
  localparam int NUM_STAGES    = 9;

  // Days from March 1 of year 0 to January 1 of the base year.
  localparam int BASE_Y1    = BASE_YEAR - 1;
  localparam int BASE_ERA   = BASE_Y1 / ERA_YEARS;
  localparam int BASE_YOE   = BASE_Y1 - BASE_ERA * ERA_YEARS;
  localparam int BASE_SHIFT = BASE_ERA * ERA_DAYS + BASE_YOE * YEAR_DAYS + BASE_YOE / 4
                              - BASE_YOE / 100 + MAR_TO_JAN;

  // Weekday offset from the 1970 anchor.
  localparam int BASE_P     = BASE_YEAR - 1;
  localparam int ANCH_P     = ANCHOR_YEAR - 1;
  localparam int EPOCH_DAYS = (ANCH_P * 365 + ANCH_P / 4 - ANCH_P / 100 + ANCH_P / 400)
                              - (BASE_P * 365 + BASE_P / 4 - BASE_P / 100 + BASE_P / 400);
  localparam int WD_OFS     = ((ANCHOR_WEEKDAY - EPOCH_DAYS) % 7 + 7) % 7;

  localparam int MAX_Z     = BASE_SHIFT + 2 ** DAY_BITS - 1;
  localparam int Z_BITS    = $clog2(MAX_Z + 1);
  localparam int ERA_MAX   = MAX_Z / ERA_DAYS;
  localparam int ERA_BITS  = $clog2(ERA_MAX + 1);
  localparam int DOE_BITS  = 18;
  localparam int YOE_BITS  = 9;
  localparam int DOY_BITS  = 9;
  localparam int DOY5_BITS = 11;
  localparam int MP_BITS   = 4;
  localparam int CENT_BITS = 3;
  localparam int Q1460_BITS = 7;
  localparam int YCALC_BITS = $clog2((ERA_MAX + 1) * ERA_YEARS + 1);

  // Exact division by a constant: floor(x / D) = (x * ceil(2^S / D)) >> S when
  // 2^S is at least the bound of x times the bound of D.
  localparam int D7_SH     = DAY_BITS + 3;
  localparam int M7_VAL    = (2 ** D7_SH + DAYS_PER_WEEK - 1) / DAYS_PER_WEEK;
  localparam int M7_BITS   = $clog2(M7_VAL + 1);
  localparam int P7_BITS   = DAY_BITS + M7_BITS;

  localparam int D1460_SH   = DOE_BITS + 11;
  localparam int M1460_VAL  = (2 ** D1460_SH + QUAD_DAYS - 1) / QUAD_DAYS;
  localparam int M1460_BITS = $clog2(M1460_VAL + 1);
  localparam int P1460_BITS = DOE_BITS + M1460_BITS;

  localparam int D365_SH   = DOE_BITS + 9;
  localparam int M365_VAL  = (2 ** D365_SH + YEAR_DAYS - 1) / YEAR_DAYS;
  localparam int M365_BITS = $clog2(M365_VAL + 1);
  localparam int P365_BITS = DOE_BITS + M365_BITS;

  localparam int D153_SH   = DOY5_BITS + 8;
  localparam int M153_VAL  = (2 ** D153_SH + 153 - 1) / 153;
  localparam int M153_BITS = $clog2(M153_VAL + 1);
  localparam int P153_BITS = DOY5_BITS + M153_BITS;

  // First day of each month within a March-based year.
  function automatic logic [DOY_BITS-1:0] month_start(input logic [MP_BITS-1:0] mp);
    logic [DOY_BITS-1:0] start;
    unique case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

@@ hdl/day_count_to_calendar_date.sv @@
// Day count to calendar date converter: pipeline, weekday path and checks.
`timescale 1ns / 1ps

// Converts a day count (day 0 is January 1, 1900) into year, month, day of
// month and weekday under the Gregorian leap rule. The datapath is a nine
// stage pipeline, and a new day count can enter every cycle while in_stall
// is low. The depth is set by the chain of constant divisions that run
// through a March-based 400-year cycle: the split into 400-year cycles and
// into centuries is done by comparison, the divisions by 1460, 365 and 153
// (and by 7 for the weekday) as reciprocal multiplies. Stages hold their
// data while out_stall is high; a bubble inside the pipeline is filled
// even while the output waits.
module day_count_to_calendar_date
  import dccd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DAY_BITS-1:0]   in_day_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [YEAR_BITS-1:0]  out_year,
  output logic [MONTH_BITS-1:0] out_month,
  output logic [MDAY_BITS-1:0]  out_day_of_month,
  output logic [WDAY_BITS-1:0]  out_weekday
);

  logic [NUM_STAGES:1] vld_r, vld_nxt, adv;

  // Stage registers.
  logic [Z_BITS-1:0]     s1_z_r, s2_z_r;
  logic [DAY_BITS-1:0]   s1_rep_r, s1_q7_r;
  logic [ERA_BITS-1:0]   s2_era_r, s3_era_r, s4_era_r, s5_era_r, s6_era_r, s7_era_r, s8_era_r;
  logic [WDAY_BITS-1:0]  s2_wd_r, s3_wd_r, s4_wd_r, s5_wd_r, s6_wd_r, s7_wd_r, s8_wd_r;
  logic [DOE_BITS-1:0]   s3_doe_r, s4_doe_r, s5_doe_r, s6_doe_r;
  logic [Q1460_BITS-1:0] s4_q1460_r;
  logic [CENT_BITS-1:0]  s4_cent_r;
  logic                  s4_last_r;
  logic [DOE_BITS-1:0]   s5_x_r;
  logic [YOE_BITS-1:0]   s6_yoe_r, s7_yoe_r, s8_yoe_r;
  logic [DOY_BITS-1:0]   s7_doy_r, s8_doy_r;
  logic [MP_BITS-1:0]    s8_mp_r;
  logic [YEAR_BITS-1:0]  s9_year_r;
  logic [MONTH_BITS-1:0] s9_month_r;
  logic [MDAY_BITS-1:0]  s9_mday_r;
  logic [WDAY_BITS-1:0]  s9_wd_r;

  // Next values.
  logic [Z_BITS-1:0]     s1_z_nxt;
  logic [DAY_BITS-1:0]   s1_q7_nxt;
  logic [P7_BITS-1:0]    p7;
  logic [ERA_BITS-1:0]   s2_era_nxt;
  logic [DAY_BITS-1:0]   r7_full;
  logic [WDAY_BITS:0]    wd_sum;
  logic [WDAY_BITS-1:0]  s2_wd_nxt;
  logic [DOE_BITS-1:0]   s3_doe_nxt;
  logic [P1460_BITS-1:0] p1460;
  logic [Q1460_BITS-1:0] s4_q1460_nxt;
  logic [CENT_BITS-1:0]  s4_cent_nxt;
  logic                  s4_last_nxt;
  logic [DOE_BITS-1:0]   s5_x_nxt;
  logic [P365_BITS-1:0]  p365;
  logic [YOE_BITS-1:0]   s6_yoe_nxt;
  logic [CENT_BITS-1:0]  yoe_cent;
  logic [DOE_BITS-1:0]   year_start;
  logic [DOY_BITS-1:0]   s7_doy_nxt;
  logic [DOY5_BITS-1:0]  doy5;
  logic [P153_BITS-1:0]  p153;
  logic [MP_BITS-1:0]    s8_mp_nxt;
  logic                  jan_feb;
  logic [YCALC_BITS-1:0] year_full;
  logic [YEAR_BITS-1:0]  s9_year_nxt;
  logic [MONTH_BITS-1:0] s9_month_nxt;
  logic [MDAY_BITS-1:0]  s9_mday_nxt;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    adv[NUM_STAGES] = !vld_r[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = vld_r;
    if (adv[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  assign in_stall = !adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: shift to a March-based day count and start the modulo 7.
  always_comb begin
    s1_z_nxt  = Z_BITS'(in_day_index) + Z_BITS'(BASE_SHIFT);
    p7        = P7_BITS'(in_day_index) * P7_BITS'(M7_VAL);
    s1_q7_nxt = DAY_BITS'(p7 >> D7_SH);
  end

  // Stage 2: era by comparison against whole 400-year cycles; weekday.
  always_comb begin
    s2_era_nxt = '0;
    for (int k = 1; k <= ERA_MAX; k++) begin
      if (s1_z_r >= Z_BITS'(k * ERA_DAYS)) begin
        s2_era_nxt = ERA_BITS'(k);
      end
    end
    r7_full = s1_rep_r - DAY_BITS'(s1_q7_r) * DAY_BITS'(DAYS_PER_WEEK);
    wd_sum  = (WDAY_BITS + 1)'(r7_full[WDAY_BITS-1:0]) + (WDAY_BITS + 1)'(WD_OFS);
    if (wd_sum >= (WDAY_BITS + 1)'(DAYS_PER_WEEK)) begin
      s2_wd_nxt = WDAY_BITS'(wd_sum - (WDAY_BITS + 1)'(DAYS_PER_WEEK));
    end else begin
      s2_wd_nxt = WDAY_BITS'(wd_sum);
    end
  end

  // Stage 3: day within the era.
  assign s3_doe_nxt = DOE_BITS'(s2_z_r - Z_BITS'(s2_era_r) * Z_BITS'(ERA_DAYS));

  // Stage 4: leap day corrections, counted in four-year and century blocks.
  always_comb begin
    p1460        = P1460_BITS'(s3_doe_r) * P1460_BITS'(M1460_VAL);
    s4_q1460_nxt = Q1460_BITS'(p1460 >> D1460_SH);
    s4_cent_nxt  = '0;
    for (int k = 1; k <= CENTS_PER_ERA; k++) begin
      if (s3_doe_r >= DOE_BITS'(k * CENT_DAYS)) begin
        s4_cent_nxt = CENT_BITS'(k);
      end
    end
    s4_last_nxt = (s3_doe_r == DOE_BITS'(ERA_DAYS - 1));
  end

  // Stage 5: day count with leap days folded out.
  assign s5_x_nxt = s4_doe_r - DOE_BITS'(s4_q1460_r) + DOE_BITS'(s4_cent_r)
                    - DOE_BITS'(s4_last_r);

  // Stage 6: year within the era.
  always_comb begin
    p365       = P365_BITS'(s5_x_r) * P365_BITS'(M365_VAL);
    s6_yoe_nxt = YOE_BITS'(p365 >> D365_SH);
  end

  // Stage 7: day within the March-based year.
  always_comb begin
    yoe_cent = '0;
    for (int k = 1; k < CENTS_PER_ERA; k++) begin
      if (s6_yoe_r >= YOE_BITS'(k * YEARS_PER_CENT)) begin
        yoe_cent = CENT_BITS'(k);
      end
    end
    year_start = DOE_BITS'(s6_yoe_r) * DOE_BITS'(YEAR_DAYS) + DOE_BITS'(s6_yoe_r >> 2)
                 - DOE_BITS'(yoe_cent);
    s7_doy_nxt = DOY_BITS'(s6_doe_r - year_start);
  end

  // Stage 8: month index, March is 0.
  always_comb begin
    doy5      = DOY5_BITS'(s7_doy_r) * DOY5_BITS'(5) + DOY5_BITS'(2);
    p153      = P153_BITS'(doy5) * P153_BITS'(M153_VAL);
    s8_mp_nxt = MP_BITS'(p153 >> D153_SH);
  end

  // Stage 9: calendar fields. January and February belong to the next year.
  always_comb begin
    jan_feb = (s8_mp_r >= MP_BITS'(MP_JAN));
    if (jan_feb) begin
      s9_month_nxt = MONTH_BITS'(s8_mp_r - MP_BITS'(MP_JAN - 1));
    end else begin
      s9_month_nxt = MONTH_BITS'(s8_mp_r + MP_BITS'(3));
    end
    s9_mday_nxt = MDAY_BITS'(s8_doy_r - month_start(s8_mp_r) + DOY_BITS'(1));
    year_full   = YCALC_BITS'(s8_era_r) * YCALC_BITS'(ERA_YEARS) + YCALC_BITS'(s8_yoe_r)
                  + YCALC_BITS'(jan_feb);
    s9_year_nxt = YEAR_BITS'(year_full);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_z_r   <= s1_z_nxt;
      s1_rep_r <= in_day_index;
      s1_q7_r  <= s1_q7_nxt;
    end
    if (adv[2]) begin
      s2_z_r   <= s1_z_r;
      s2_era_r <= s2_era_nxt;
      s2_wd_r  <= s2_wd_nxt;
    end
    if (adv[3]) begin
      s3_doe_r <= s3_doe_nxt;
      s3_era_r <= s2_era_r;
      s3_wd_r  <= s2_wd_r;
    end
    if (adv[4]) begin
      s4_doe_r   <= s3_doe_r;
      s4_q1460_r <= s4_q1460_nxt;
      s4_cent_r  <= s4_cent_nxt;
      s4_last_r  <= s4_last_nxt;
      s4_era_r   <= s3_era_r;
      s4_wd_r    <= s3_wd_r;
    end
    if (adv[5]) begin
      s5_x_r   <= s5_x_nxt;
      s5_doe_r <= s4_doe_r;
      s5_era_r <= s4_era_r;
      s5_wd_r  <= s4_wd_r;
    end
    if (adv[6]) begin
      s6_yoe_r <= s6_yoe_nxt;
      s6_doe_r <= s5_doe_r;
      s6_era_r <= s5_era_r;
      s6_wd_r  <= s5_wd_r;
    end
    if (adv[7]) begin
      s7_doy_r <= s7_doy_nxt;
      s7_yoe_r <= s6_yoe_r;
      s7_era_r <= s6_era_r;
      s7_wd_r  <= s6_wd_r;
    end
    if (adv[8]) begin
      s8_mp_r  <= s8_mp_nxt;
      s8_doy_r <= s7_doy_r;
      s8_yoe_r <= s7_yoe_r;
      s8_era_r <= s7_era_r;
      s8_wd_r  <= s7_wd_r;
    end
    if (adv[9]) begin
      s9_year_r  <= s9_year_nxt;
      s9_month_r <= s9_month_nxt;
      s9_mday_r  <= s9_mday_nxt;
      s9_wd_r    <= s8_wd_r;
    end
  end

  assign out_valid        = vld_r[NUM_STAGES];
  assign out_year         = s9_year_r;
  assign out_month        = s9_month_r;
  assign out_day_of_month = s9_mday_r;
  assign out_weekday      = s9_wd_r;

`include "day_count_to_calendar_date_macros.svh"

  `DCCD_ASSERT_NEXT(a_enter_stage1, in_valid && !in_stall, vld_r[1], "accepted beat did not enter stage 1")
  `DCCD_ASSERT_NOW(a_march_index, vld_r[8], (s8_mp_r <= MP_BITS'(11)) && (s8_doy_r <= DOY_BITS'(YEAR_DAYS)), "month index or day of year out of range")
  `DCCD_ASSERT_NOW(a_month_range, out_valid, (out_month != '0) && (out_month <= MONTH_BITS'(12)), "month out of range")
  `DCCD_ASSERT_NOW(a_day_range, out_valid, (out_day_of_month != '0) && (out_month != MONTH_BITS'(2) || out_day_of_month <= MDAY_BITS'(29)) && (out_weekday < WDAY_BITS'(DAYS_PER_WEEK)), "day of month or weekday out of range")

endmodule
